// ===== rtl/spvm_pkg.sv =====
package spvm_pkg;

  // Field widths of the scan and result words.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAZE_W  = 16;
  localparam int unsigned AMP_W   = GAZE_W + 1;

  // Configuration port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register index, taken from the word address (byte address / 4).
  typedef enum logic [0:0] {
    REG_EYE_SELECT = 1'b0
  } reg_index_t;

  // Eye selection codes.
  typedef enum logic [0:0] {
    EYE_RIGHT = 1'b0,
    EYE_LEFT  = 1'b1
  } eye_t;

  // One scan word, first field in the lowest bits.
  typedef struct packed {
    logic signed [GAZE_W-1:0]  left_gaze_y;
    logic signed [GAZE_W-1:0]  left_gaze_x;
    logic signed [GAZE_W-1:0]  right_gaze_y;
    logic signed [GAZE_W-1:0]  right_gaze_x;
    logic        [SPEED_W-1:0] left_speed;
    logic        [SPEED_W-1:0] right_speed;
    logic        [TIME_W-1:0]  scan_time;
  } scan_t;

  localparam int unsigned RESULT_BITS = SPEED_W + 4 * TIME_W + 2 * AMP_W;
  localparam int unsigned RESULT_PAD  = (8 - (RESULT_BITS % 8)) % 8;
  localparam int unsigned RESULT_W    = RESULT_BITS + RESULT_PAD;

  // One result word, first field in the lowest bits, zero filled at the top.
  typedef struct packed {
    logic        [RESULT_PAD-1:0] pad;
    logic signed [AMP_W-1:0]      amplitude_y;
    logic signed [AMP_W-1:0]      amplitude_x;
    logic        [TIME_W-1:0]     total_time;
    logic        [TIME_W-1:0]     fall_time;
    logic        [TIME_W-1:0]     plateau_time;
    logic        [TIME_W-1:0]     rise_time;
    logic        [SPEED_W-1:0]    peak_speed;
  } result_t;

endpackage

// ===== rtl/saccade_peak_velocity_metrics.sv =====
// Channel   Direction  Width  Contents
// s_axis    in         128    one scan; tlast marks the final scan of a saccade
// m_axis    out        184    one result per saccade, on its final scan
// apb       in/out     32     eye_select at byte address 0
//
// The velocity compare and peak-time update sit in front of the segment
// registers, so a new scan can enter every cycle while s_axis_tready is high.
// The result of a final scan shows on m_axis in the cycle after it is taken.
// A waiting result stalls the input only while m_axis_tready is low.
// rst is synchronous and clears the segment state and the result valid.
module saccade_peak_velocity_metrics (
  input  logic                                 clk,
  input  logic                                 rst,
  // Scan input.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: scan_time, right_speed, left_speed, right_gaze_x,
  // right_gaze_y, left_gaze_x, left_gaze_y.
  input  logic [$bits(spvm_pkg::scan_t)-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // Result output.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0 up: peak_speed, rise_time, plateau_time, fall_time,
  // total_time, amplitude_x, amplitude_y, then zero fill.
  output logic [spvm_pkg::RESULT_W-1:0]        m_axis_tdata,
  // Configuration.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [spvm_pkg::ADDR_W-1:0]          paddr,
  input  logic [spvm_pkg::DATA_W-1:0]          pwdata,
  output logic [spvm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int unsigned TW = spvm_pkg::TIME_W;
  localparam int unsigned SW = spvm_pkg::SPEED_W;
  localparam int unsigned GW = spvm_pkg::GAZE_W;
  localparam int unsigned AW = spvm_pkg::AMP_W;

  spvm_pkg::eye_t    eye_select;
  logic              in_segment;
  logic [TW-1:0]     start_time;
  logic [SW-1:0]     best_speed;
  logic [TW-1:0]     peak_first_time;
  logic [TW-1:0]     peak_last_time;
  logic signed [GW-1:0] start_gaze_x;
  logic signed [GW-1:0] start_gaze_y;
  spvm_pkg::result_t result;

  spvm_pkg::scan_t   scan;
  logic              accept;
  logic              reg_hit;
  logic [SW-1:0]     speed;
  logic signed [GW-1:0] gaze_x;
  logic signed [GW-1:0] gaze_y;
  logic              opening;
  logic [TW-1:0]     start_time_next;
  logic [SW-1:0]     best_base;
  logic [SW-1:0]     best_speed_next;
  logic [TW-1:0]     peak_first_time_next;
  logic [TW-1:0]     peak_last_time_next;
  logic signed [GW-1:0] start_gaze_x_next;
  logic signed [GW-1:0] start_gaze_y_next;
  spvm_pkg::result_t result_next;

  // Configuration port: always ready, one register decoded on the word address.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[spvm_pkg::ADDR_W-1:2] == spvm_pkg::REG_EYE_SELECT);

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_select <= spvm_pkg::EYE_RIGHT;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      eye_select <= spvm_pkg::eye_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[0] = eye_select;
    end
  end

  // A scan is taken whenever the result register is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scan          = spvm_pkg::scan_t'(s_axis_tdata);

  // Pick the measured eye.
  always_comb begin
    case (eye_select)
      spvm_pkg::EYE_LEFT: begin
        speed  = scan.left_speed;
        gaze_x = scan.left_gaze_x;
        gaze_y = scan.left_gaze_y;
      end
      default: begin
        speed  = scan.right_speed;
        gaze_x = scan.right_gaze_x;
        gaze_y = scan.right_gaze_y;
      end
    endcase
  end

  // Segment update: an opening scan restarts the state, then the velocity
  // is compared against the running peak.
  always_comb begin
    opening              = !in_segment;
    start_time_next      = opening ? scan.scan_time : start_time;
    start_gaze_x_next    = opening ? gaze_x : start_gaze_x;
    start_gaze_y_next    = opening ? gaze_y : start_gaze_y;
    best_base            = opening ? '0 : best_speed;
    best_speed_next      = best_base;
    peak_first_time_next = opening ? scan.scan_time : peak_first_time;
    peak_last_time_next  = opening ? scan.scan_time : peak_last_time;
    if (speed > best_base) begin
      best_speed_next      = speed;
      peak_first_time_next = scan.scan_time;
      peak_last_time_next  = scan.scan_time;
    end else if (speed == best_base) begin
      peak_last_time_next  = scan.scan_time;
    end
  end

  // Result of a final scan; durations wrap modulo 2^32.
  always_comb begin
    result_next              = '0;
    result_next.peak_speed   = best_speed_next;
    result_next.rise_time    = peak_first_time_next - start_time_next;
    result_next.plateau_time = peak_last_time_next - peak_first_time_next;
    result_next.fall_time    = scan.scan_time - peak_last_time_next;
    result_next.total_time   = scan.scan_time - start_time_next;
    result_next.amplitude_x  = AW'(start_gaze_x_next) - AW'(gaze_x);
    result_next.amplitude_y  = AW'(start_gaze_y_next) - AW'(gaze_y);
  end

  // Segment control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_segment      <= 1'b0;
      start_time      <= '0;
      best_speed      <= '0;
      peak_first_time <= '0;
      peak_last_time  <= '0;
      start_gaze_x    <= '0;
      start_gaze_y    <= '0;
    end else if (accept) begin
      in_segment      <= !s_axis_tlast;
      start_time      <= start_time_next;
      best_speed      <= best_speed_next;
      peak_first_time <= peak_first_time_next;
      peak_last_time  <= peak_last_time_next;
      start_gaze_x    <= start_gaze_x_next;
      start_gaze_y    <= start_gaze_y_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = result;

  // A non-final scan leaves a segment open.
  a_open_after_scan: assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tlast |=> in_segment)
    else $error("segment not open after a non-final scan");

  // A final scan closes the segment and presents a result.
  a_close_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> !in_segment && m_axis_tvalid)
    else $error("final scan did not close the segment with a result");

  // The three phases add up to the total duration.
  a_phase_sum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (TW'(result.rise_time + result.plateau_time
                           + result.fall_time) == result.total_time))
    else $error("rise, plateau and fall do not sum to total");

  // Peak times stay ordered relative to each other within an open segment
  // only in the wrapping sense, so check the peak speed held is the best.
  a_peak_held: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> result.peak_speed == $past(best_speed_next))
    else $error("result peak speed differs from tracked peak");

endmodule
